>>> hw/rtl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg: shared codes and types of the byte delta codec
// Mode codes of the input channel, the kinds of work that follow the store
// read, and the burst word handed to the result emitter.
// ----------------------------------------------------------------------------
package bdc_pkg;

	localparam logic [1:0] MODE_ENCODE = 2'd0;
	localparam logic [1:0] MODE_DECODE = 2'd1;
	localparam logic [1:0] MODE_LOAD   = 2'd2;
	localparam logic [1:0] MODE_READ   = 2'd3;

	// work left for the stage after the store read
	localparam logic [1:0] KIND_QUIET  = 2'd0;
	localparam logic [1:0] KIND_ENCODE = 2'd1;
	localparam logic [1:0] KIND_RAW    = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;

	localparam int GROUP_SIZE = 8;

	// one burst of results: a tag plus up to eight changed bytes, or one single word
	typedef struct packed {
		logic                        single;
		logic                        last;
		logic [3:0]                  cnt;
		logic [7:0]                  tag;
		logic [GROUP_SIZE-1:0][7:0]  data;
	} emit_load_t;

endpackage

>>> hw/rtl/bdc_store.sv
// ----------------------------------------------------------------------------
// bdc_store: version byte store
// Single-port-write, single-port-read synchronous memory with a registered
// read and write-to-read forwarding on a same-cycle address match.
// ----------------------------------------------------------------------------
module bdc_store
	import bdc_pkg::*;
#(
	parameter int DEPTH = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [7:0]                 wdata,
	output logic [7:0]                 rdata
);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic [7:0]    fwd_data_q;
	logic          fwd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q       <= mem[raddr];
			fwd_data_q <= wdata;
		end
	end

	// the write lands at the same edge as the read, so the read would miss it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (re) begin
			fwd_q <= we && (waddr == raddr);
		end
	end

	assign rdata = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> hw/rtl/bdc_emit.sv
// ----------------------------------------------------------------------------
// bdc_emit: result emitter
// Holds one burst (a group tag with its changed bytes, or one single word)
// and sends it one word per cycle on the result channel while result_ready is high.
// ----------------------------------------------------------------------------
module bdc_emit
	import bdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load_valid,
	input  emit_load_t  load,
	output logic        free,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  out_byte,
	output logic        is_tag,
	output logic        encoded,
	output logic        packet_end,
	output logic        run_last
);

	logic        busy_q;
	logic [3:0]  idx_q;
	emit_load_t  ld_q;
	logic [3:0]  final_idx;
	logic [3:0]  idx_m1;
	logic        done;
	logic        take;

	assign final_idx = ld_q.single ? 4'd0 : ld_q.cnt;
	assign done      = busy_q && result_ready && (idx_q == final_idx);
	assign free      = !busy_q || done;
	assign take      = load_valid && free;
	assign idx_m1    = idx_q - 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 4'd0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= 4'd0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && result_ready) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ld_q <= load;
		end
	end

	always_comb begin
		if (ld_q.single) begin
			out_byte   = ld_q.data[0];
			is_tag     = 1'b0;
			encoded    = 1'b0;
			packet_end = ld_q.last;
			run_last   = 1'b1;
		end else if (idx_q == 4'd0) begin
			out_byte   = ld_q.tag;
			is_tag     = 1'b1;
			encoded    = 1'b1;
			packet_end = (ld_q.cnt == 4'd0) && ld_q.last;
			run_last   = (ld_q.cnt == 4'd0);
		end else begin
			out_byte   = ld_q.data[idx_m1[2:0]];
			is_tag     = 1'b0;
			encoded    = 1'b1;
			packet_end = (idx_q == ld_q.cnt) && ld_q.last;
			run_last   = (idx_q == ld_q.cnt);
		end
	end

	assign result_valid = busy_q;

endmodule

>>> hw/rtl/byte_delta_codec_core.sv
// ----------------------------------------------------------------------------
// byte_delta_codec_core: byte store with bitmask delta encode and decode
// Keeps the latest packet version in a byte store and sends only the changed
// bytes, one tag byte per group of eight (the whole packet raw if its length
// changed), or patches the store from such a stream.
// ----------------------------------------------------------------------------
// Usage
//   Item channel (item_valid/item_ready) takes one word per cycle while
//   item_ready is high: mode, data_byte, packet_length, read_index,
//   last_byte. Result channel (result_valid/result_ready) gives one word
//   per cycle while result_ready is high. An accepted item is registered
//   into the stage after the store read, then updated and handed to the emitter.
//   Throughput: one item per cycle while the result side keeps up. A group
//   end emits its tag and changed bytes one per cycle from the emitter; the
//   emitter's one word per cycle sets the sustained rate. A decode data byte
//   right behind an encode byte waits until that byte leaves the stage after
//   the store read and has set its tag bit.
//   A stalled receiver holds the current result; the item channel keeps
//   going until a second burst is ready, then item_ready drops.
//   Reset clears the position, lengths, group state and pipeline at once.
//   The store itself is not cleared and holds no data until written.
// ----------------------------------------------------------------------------
module byte_delta_codec_core
	import bdc_pkg::*;
#(
	parameter int MAX_LEN = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  logic [1:0]   mode,
	input  logic [7:0]   data_byte,
	input  logic [11:0]  packet_length,
	input  logic [10:0]  read_index,
	input  logic         last_byte,
	output logic         result_valid,
	input  logic         result_ready,
	output logic [7:0]   out_byte,
	output logic         is_tag,
	output logic         encoded,
	output logic         packet_end,
	output logic         run_last
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int PW = $clog2(MAX_LEN + 1);
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);
	localparam logic [3:0] GRP = 4'(GROUP_SIZE);

	// sequencing state, updated when an item is accepted
	logic [PW-1:0]  pos_q;
	logic [11:0]    slen_q;
	logic           enc_act_q;
	logic [3:0]     gbit_q;
	logic           exp_tag_q;
	// group state, shared by both stages (the byte buffer only by the later one)
	logic [7:0]     gtag_q;
	logic [2:0]     clow_q;
	logic           covf_q;
	logic [GROUP_SIZE-1:0][7:0] cbuf_q;

	// stage after the store read
	logic           valid_s1;
	logic [1:0]     kind_s1;
	logic [7:0]     data_s1;
	logic           last_s1;
	logic           flush_s1;
	logic [2:0]     bit_s1;
	logic [AW-1:0]  addr_s1;
	logic           inrange_s1;
	logic           we_s1;

	// front-end next values
	logic [PW-1:0]  p_n;
	logic [11:0]    sl_n;
	logic           ea_n;
	logic [3:0]     gb_n;
	logic           exp_n;
	logic           tag_ovr;
	logic [7:0]     tag_val;
	logic           grp_clr;
	logic [1:0]     kind_n;
	logic           we_n;
	logic           flush_n;
	logic [2:0]     bit_n;
	logic [7:0]     tg;
	logic [3:0]     skip;
	logic [PW:0]    skip_sum;
	logic [AW-1:0]  addr_n;
	logic           inrange_n;
	logic [31:0]    ridx_ext;
	logic [31:0]    pos_ext;

	logic           accept;
	logic           hazard;
	logic           fire;
	logic           emits;
	logic           emit_free;
	logic [7:0]     rdata;
	logic [7:0]     old_byte;
	logic           chg;
	logic [7:0]     tag_full;
	logic [GROUP_SIZE-1:0][7:0] buf_new;
	logic [2:0]     clow_n;
	logic           covf_n;
	logic [3:0]     cnt_min;
	emit_load_t     load;

	assign ridx_ext = 32'(read_index);
	assign pos_ext  = 32'(pos_q);

	always_comb begin
		p_n       = pos_q;
		sl_n      = slen_q;
		ea_n      = enc_act_q;
		gb_n      = gbit_q;
		exp_n     = exp_tag_q;
		tag_ovr   = 1'b0;
		tag_val   = 8'h00;
		grp_clr   = 1'b0;
		kind_n    = KIND_QUIET;
		we_n      = 1'b0;
		flush_n   = 1'b0;
		bit_n     = 3'd0;
		tg        = gtag_q;
		skip      = 4'd0;
		skip_sum  = '0;
		addr_n    = pos_ext[AW-1:0];
		inrange_n = (pos_q < MAX_POS);
		case (mode)
			MODE_READ: begin
				kind_n    = KIND_READ;
				addr_n    = ridx_ext[AW-1:0];
				inrange_n = (ridx_ext < 32'(MAX_LEN));
			end
			MODE_DECODE: begin
				if (exp_tag_q) begin
					tg      = data_byte;
					gb_n    = 4'd0;
					exp_n   = 1'b0;
					tag_ovr = 1'b1;
					tag_val = data_byte;
				end else begin
					we_n = 1'b1;
					skip = 4'd1;
					gb_n = gbit_q + 4'd1;
				end
				// positions whose tag bit is clear are skipped at once
				for (int i = 0; i < GROUP_SIZE; i++) begin
					if (gb_n < GRP && !tg[gb_n[2:0]]) begin
						gb_n = gb_n + 4'd1;
						skip = skip + 4'd1;
					end
				end
				skip_sum = {1'b0, pos_q} + (PW+1)'(skip);
				p_n = (skip_sum > {1'b0, MAX_POS}) ? MAX_POS : skip_sum[PW-1:0];
				if (gb_n >= GRP) begin
					exp_n = 1'b1;
				end
				if (last_byte) begin
					p_n     = '0;
					exp_n   = 1'b1;
					tag_ovr = 1'b1;
					tag_val = 8'h00;
					gb_n    = 4'd0;
				end
			end
			default: begin
				// encode and raw load
				if (pos_q == '0) begin
					ea_n    = (mode == MODE_ENCODE) && (packet_length == slen_q);
					sl_n    = packet_length;
					gb_n    = 4'd0;
					tag_ovr = 1'b1;
					tag_val = 8'h00;
					grp_clr = 1'b1;
				end
				we_n = 1'b1;
				if (mode == MODE_LOAD) begin
					kind_n = KIND_QUIET;
				end else if (ea_n) begin
					kind_n  = KIND_ENCODE;
					bit_n   = gb_n[2:0];
					gb_n    = gb_n + 4'd1;
					flush_n = (gb_n >= GRP) || last_byte;
					if (flush_n) begin
						gb_n = 4'd0;
					end
				end else begin
					kind_n = KIND_RAW;
				end
				p_n = (pos_q < MAX_POS) ? pos_q + PW'(1) : pos_q;
				if (last_byte) begin
					p_n = '0;
				end
			end
		endcase
	end

	// a decode data byte reads the tag that the encode byte in flight still updates
	assign hazard = valid_s1 && (kind_s1 == KIND_ENCODE) &&
		(mode == MODE_DECODE) && !exp_tag_q;

	assign emits = (kind_s1 != KIND_QUIET) && ((kind_s1 != KIND_ENCODE) || flush_s1);
	assign fire  = valid_s1 && (!emits || emit_free);
	assign item_ready = (!valid_s1 || fire) && !hazard;
	assign accept     = item_valid && item_ready;

	// back end of the stage after the read
	assign old_byte = inrange_s1 ? rdata : 8'h00;
	assign chg      = (old_byte != data_s1);
	assign tag_full = gtag_q | (chg ? (8'h01 << bit_s1) : 8'h00);
	assign clow_n   = clow_q + {2'b00, chg};
	assign covf_n   = covf_q || (chg && (clow_q == 3'd7));
	assign cnt_min  = covf_n ? GRP : {1'b0, clow_n};

	always_comb begin
		buf_new = cbuf_q;
		if (chg) begin
			buf_new[clow_q] = data_s1;
		end
	end

	always_comb begin
		load        = '0;
		load.last   = last_s1;
		load.data   = buf_new;
		load.tag    = tag_full;
		load.cnt    = cnt_min;
		case (kind_s1)
			KIND_RAW: begin
				load.single  = 1'b1;
				load.data[0] = data_s1;
			end
			KIND_READ: begin
				load.single  = 1'b1;
				load.last    = 1'b0;
				load.data[0] = old_byte;
			end
			default: begin
				load.single = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			slen_q    <= 12'd0;
			enc_act_q <= 1'b0;
			gbit_q    <= 4'd0;
			exp_tag_q <= 1'b1;
			gtag_q    <= 8'h00;
			clow_q    <= 3'd0;
			covf_q    <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			// older item first, then the item accepted at this edge
			if (fire && (kind_s1 == KIND_ENCODE)) begin
				gtag_q <= flush_s1 ? 8'h00 : tag_full;
				clow_q <= flush_s1 ? 3'd0 : clow_n;
				covf_q <= flush_s1 ? 1'b0 : covf_n;
			end
			if (accept) begin
				pos_q     <= p_n;
				slen_q    <= sl_n;
				enc_act_q <= ea_n;
				gbit_q    <= gb_n;
				exp_tag_q <= exp_n;
				if (tag_ovr) begin
					gtag_q <= tag_val;
				end
				if (grp_clr) begin
					clow_q <= 3'd0;
					covf_q <= 1'b0;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (kind_s1 == KIND_ENCODE)) begin
			cbuf_q <= buf_new;
		end
		if (accept) begin
			kind_s1    <= kind_n;
			data_s1    <= data_byte;
			last_s1    <= last_byte;
			flush_s1   <= flush_n;
			bit_s1     <= bit_n;
			addr_s1    <= addr_n;
			inrange_s1 <= inrange_n;
			we_s1      <= we_n;
		end
	end

	bdc_store #(
		.DEPTH (MAX_LEN)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (accept),
		.raddr  (addr_n),
		.we     (fire && we_s1 && inrange_s1),
		.waddr  (addr_s1),
		.wdata  (data_s1),
		.rdata  (rdata)
	);

	bdc_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (valid_s1 && emits),
		.load         (load),
		.free         (emit_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.is_tag       (is_tag),
		.encoded      (encoded),
		.packet_end   (packet_end),
		.run_last     (run_last)
	);

endmodule

>>> hw/rtl/bdc_checker.sv
// ----------------------------------------------------------------------------
// bdc_checker: port-level checks of the byte delta codec
// Watches the result channel for handshake hold and the consistency of the
// result flags over a burst.
// ----------------------------------------------------------------------------
module bdc_checker
	import bdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [7:0]  out_byte,
	input  logic        is_tag,
	input  logic        encoded,
	input  logic        packet_end,
	input  logic        run_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_byte) &&
		$stable(is_tag) && $stable(run_last))
		else $error("stalled result word changed");

	a_tag_enc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_tag |-> encoded)
		else $error("tag word outside an encoded packet");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && packet_end |-> run_last)
		else $error("packet end not on the last word of its run");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !encoded |-> run_last)
		else $error("raw or read word not alone in its run");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !run_last |=> result_valid && encoded && !is_tag)
		else $error("burst broken after a word that is not last");

endmodule

bind byte_delta_codec_core bdc_checker u_bdc_checker (.*);
